/* src/stis_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table interpolation search: shared package
// Entry layout, result status codes, controller states and size defaults.
// ----------------------------------------------------------------------------
package stis_pkg;

   // Default number of table entries.
   localparam int unsigned DefaultDepth = 64;

   // Widths of the fixed fields.
   localparam int unsigned IdWidth     = 32;
   localparam int unsigned GroupWidth  = 16;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned PosWidth    = 6;

   // Request tdata: is_male, record_id, group_number (49 bits, padded to 56).
   localparam int unsigned ReqDataWidth = 56;
   // Response tdata: status, position, found_group (24 bits).
   localparam int unsigned RspDataWidth = 24;

   // Request kinds carried on tuser.
   localparam logic FuncInsert = 1'b0;
   localparam logic FuncSearch = 1'b1;

   // Result status codes.
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // One table word: class bit, record id and group.
   typedef struct packed {
      logic                  cls;
      logic [IdWidth-1:0]    id;
      logic [GroupWidth-1:0] grp;
   } entry_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE_NEW,
      ST_LO_RD,
      ST_LO_CHK,
      ST_HI_CHK,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PROBE_CHK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

/* src/sorted_table_interpolation_search_unit.sv */
`default_nettype none
// An insert scans the stored entries until one sorts after the new entry, then
// shifts the entries above its slot up by one; a search scans for the class-1
// run, then runs probes that each wait on the serial divider. One item is in
// work at a time; a finished result waits in the output register while the
// next item is accepted. Reset is synchronous and empties the table; stored
// words are not cleared.
// ----------------------------------------------------------------------------
// Sorted table interpolation search unit
// Keeps entries sorted by class then record id in a simple dual-port memory
// and runs interpolation search over the class-1 entries.
// ----------------------------------------------------------------------------
module sorted_table_interpolation_search_unit #(
   parameter int unsigned TABLE_DEPTH = stis_pkg::DefaultDepth
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: is_male[0], record_id[32:1], group_number[48:33], zero pad
   input  wire logic [stis_pkg::ReqDataWidth-1:0]  req_tdata,
   // tuser: func (0 insert, 1 search)
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: status[1:0], position[7:2], found_group[23:8]
   output logic [stis_pkg::RspDataWidth-1:0]       rsp_tdata
);
   import stis_pkg::*;

   localparam int unsigned IW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned DW = IdWidth + IW;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  func_ff, func_in;
   logic                  cls_ff, cls_in;
   logic [IdWidth-1:0]    key_ff, key_in;
   logic [GroupWidth-1:0] grp_ff, grp_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         pos_ff, pos_in;
   logic [IW-1:0]         left_ff, left_in;
   logic [IW-1:0]         right_ff, right_in;
   logic [IdWidth-1:0]    lo_ff, lo_in;
   logic [GroupWidth-1:0] lo_grp_ff, lo_grp_in;
   logic [IdWidth-1:0]    hi_ff, hi_in;
   logic [DW-1:0]         num_ff, num_in;
   status_type            res_status_ff, res_status_in;
   logic [PosWidth-1:0]   res_pos_ff, res_pos_in;
   logic [GroupWidth-1:0] res_grp_ff, res_grp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [IW-1:0] mem_raddr;
   entry_type     mem_rdata;
   logic          div_start;
   logic          div_done;
   logic [DW-1:0] div_quo;
   logic [IW-1:0] last_idx;
   logic [IW-1:0] probe_idx;
   logic          req_fire;
   logic          sorts_before;

   stis_table_mem #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .AW         (IW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   stis_divider #(
      .DW(DW),
      .VW(IdWidth)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(num_ff),
      .divisor (hi_ff - lo_ff),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign last_idx     = IW'(count_ff - CW'(1));
   assign probe_idx    = left_ff + div_quo[IW-1:0];
   assign sorts_before = (cls_ff < mem_rdata.cls) ||
                         ((cls_ff == mem_rdata.cls) && (key_ff < mem_rdata.id));

   // Controller: next state, memory accesses and result.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      cls_in        = cls_ff;
      key_in        = key_ff;
      grp_in        = grp_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      lo_in         = lo_ff;
      lo_grp_in     = lo_grp_ff;
      hi_in         = hi_ff;
      num_in        = num_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_grp_in    = res_grp_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = mem_rdata;
      mem_raddr     = idx_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in       = req_tuser;
               cls_in        = req_tdata[0];
               key_in        = req_tdata[32:1];
               grp_in        = req_tdata[48:33];
               idx_in        = '0;
               pos_in        = '0;
               res_status_in = STATUS_NOT_FOUND;
               res_pos_in    = '0;
               res_grp_in    = '0;
               if (count_ff == '0) begin
                  state_in = (req_tuser == FuncInsert) ? ST_WRITE_NEW : ST_RESP;
               end else if (req_tuser == FuncInsert &&
                            count_ff >= CW'(TABLE_DEPTH)) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end

         ST_SCAN_RD: begin
            mem_raddr = idx_ff;
            state_in  = ST_SCAN_CHK;
         end

         // Insert looks for the first entry that sorts after the new one;
         // search looks for the first class-1 entry.
         ST_SCAN_CHK: begin
            if (func_ff == FuncInsert) begin
               if (sorts_before) begin
                  pos_in   = idx_ff;
                  idx_in   = IW'(count_ff);
                  state_in = ST_SHIFT_RD;
               end else if (idx_ff == last_idx) begin
                  pos_in   = IW'(count_ff);
                  state_in = ST_WRITE_NEW;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_SCAN_RD;
               end
            end else begin
               if (mem_rdata.cls) begin
                  left_in  = idx_ff;
                  right_in = last_idx;
                  state_in = ST_LO_RD;
               end else if (idx_ff == last_idx) begin
                  state_in = ST_RESP;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_SCAN_RD;
               end
            end
         end

         // Shift entries up by one, top first.
         ST_SHIFT_RD: begin
            mem_raddr = idx_ff - IW'(1);
            state_in  = (idx_ff == pos_ff) ? ST_WRITE_NEW : ST_SHIFT_WR;
         end

         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = mem_rdata;
            idx_in    = idx_ff - IW'(1);
            state_in  = ST_SHIFT_RD;
         end

         ST_WRITE_NEW: begin
            mem_we        = 1'b1;
            mem_waddr     = pos_ff;
            mem_wdata     = '{cls: cls_ff, id: key_ff, grp: grp_ff};
            count_in      = count_ff + CW'(1);
            res_status_in = STATUS_OK;
            res_pos_in    = PosWidth'(pos_ff);
            state_in      = ST_RESP;
         end

         ST_LO_RD: begin
            mem_raddr = left_ff;
            state_in  = ST_LO_CHK;
         end

         ST_LO_CHK: begin
            lo_in     = mem_rdata.id;
            lo_grp_in = mem_rdata.grp;
            mem_raddr = right_ff;
            state_in  = (key_ff < mem_rdata.id) ? ST_RESP : ST_HI_CHK;
         end

         // Span check, then the degenerate span with equal end ids.
         ST_HI_CHK: begin
            hi_in = mem_rdata.id;
            if (key_ff > mem_rdata.id) begin
               state_in = ST_RESP;
            end else if (lo_ff == mem_rdata.id) begin
               if (lo_ff == key_ff) begin
                  res_status_in = STATUS_OK;
                  res_pos_in    = PosWidth'(left_ff);
                  res_grp_in    = lo_grp_ff;
               end
               state_in = ST_RESP;
            end else begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            num_in   = DW'(key_ff - lo_ff) * DW'(right_ff - left_ff);
            state_in = ST_DIV_START;
         end

         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            mem_raddr = probe_idx;
            if (div_done) begin
               pos_in   = probe_idx;
               state_in = ST_PROBE_CHK;
            end
         end

         // Compare the probe and narrow the span.
         ST_PROBE_CHK: begin
            if (!mem_rdata.cls) begin
               state_in = ST_RESP;
            end else if (mem_rdata.id == key_ff) begin
               res_status_in = STATUS_OK;
               res_pos_in    = PosWidth'(pos_ff);
               res_grp_in    = mem_rdata.grp;
               state_in      = ST_RESP;
            end else if (mem_rdata.id < key_ff) begin
               left_in  = pos_ff + IW'(1);
               state_in = (pos_ff == right_ff) ? ST_RESP : ST_LO_RD;
            end else begin
               right_in = pos_ff - IW'(1);
               state_in = (pos_ff == left_ff) ? ST_RESP : ST_LO_RD;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded when a result leaves ST_RESP, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_grp_ff, res_pos_ff, res_status_ff};
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      cls_ff        <= cls_in;
      key_ff        <= key_in;
      grp_ff        <= grp_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      lo_ff         <= lo_in;
      lo_grp_ff     <= lo_grp_in;
      hi_ff         <= hi_in;
      num_ff        <= num_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_grp_ff    <= res_grp_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SHIFT_WR || state_ff == ST_WRITE_NEW))
      else $error("table write outside insert");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished while controller not waiting");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] == STATUS_FULL) |-> rsp_data_ff[23:2] == '0)
      else $error("table full result carries data");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && !$past(reset)) |-> $past(state_ff) == ST_WRITE_NEW)
      else $error("entry count changed outside insert");
`endif

endmodule

`default_nettype wire

/* src/stis_table_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table interpolation search: entry memory
// Single write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module stis_table_mem #(
   parameter int unsigned TABLE_DEPTH = stis_pkg::DefaultDepth,
   parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire stis_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output stis_pkg::entry_type      rd_data
);
   import stis_pkg::*;

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/stis_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table interpolation search: restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module stis_divider #(
   parameter int unsigned DW = 38,
   parameter int unsigned VW = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);
   import stis_pkg::*;

   localparam int unsigned CntW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [VW-1:0]   dvs_ff, dvs_in;
   logic [VW:0]     trial;

   // One restoring step per cycle: the dividend shifts out of quo_ff while
   // the quotient bits shift in.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = VW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
